// File: sv/assert_macros.svh
// Assertion macros used by the checker file bdll_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bdll_pkg.sv
// Types and constants of the bounded doubly linked list.
package bdll_pkg;

  localparam int KEY_W  = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] NULL_LINK = 7'h7F;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        entry_count;
    logic                    last_result;
  } out_item_t;

endpackage

// File: sv/bdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bounded_doubly_linked_list.sv
// Bounded doubly linked list: keys and links in RAMs, free map and ends in flops.
// Insert: from idle on an empty list, else via S_INS, which back-links the old head.
// Delete first/last: unlinked in S_WALK; delete by key walks S_WALK to the match or tail.
// Dump: walks from the head in S_WALK, one key per cycle.
// Throughput: busy falls with the final result, so the next transfer can overlap it.
// Synchronous active-low reset empties the list at once; RAM contents are not cleared.
module bounded_doubly_linked_list #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bdll_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bdll_pkg::out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = bdll_pkg::LINK_W;
  localparam int CW = bdll_pkg::CNT_W;
  localparam int KW = bdll_pkg::KEY_W;

  typedef enum logic [1:0] {S_IDLE, S_INS, S_WALK} state_t;

  state_t                    state_r, state_nxt;
  logic [LW-1:0]             head_r, head_nxt;
  logic [LW-1:0]             tail_r, tail_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CAPACITY-1:0]       free_map_r, free_map_nxt;
  logic                      out_valid_r, out_valid_nxt;
  bdll_pkg::out_item_t       out_item_r, out_item_nxt;
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [AW-1:0]             slot_r, slot_nxt;
  logic [bdll_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KW-1:0]             key_r, key_nxt;

  logic [AW-1:0] free_slot;

  // RAM ports
  logic          key_we, nxt_we, prv_we;
  logic [AW-1:0] key_waddr, nxt_waddr, prv_waddr, raddr;
  logic [KW-1:0] key_wdata, key_rd;
  logic [LW-1:0] nxt_wdata, prv_wdata, nxt_rd, prv_rd;

  bdll_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rd)
  );

  bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(raddr), .rdata(nxt_rd)
  );

  bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(raddr), .rdata(prv_rd)
  );

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map_r[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  always_comb begin
    logic          head_ok, nxt_ok, prv_ok, hit;
    logic [LW-1:0] h, t;

    head_ok = head_r < LW'(CAPACITY);
    nxt_ok  = nxt_rd < LW'(CAPACITY);
    prv_ok  = prv_rd < LW'(CAPACITY);
    hit     = 1'b0;
    h       = head_r;
    t       = tail_r;

    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    free_map_nxt  = free_map_r;
    cur_nxt       = cur_r;
    slot_nxt      = slot_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    key_we    = 1'b0;
    key_waddr = free_slot;
    key_wdata = in_item.key_value;
    nxt_we    = 1'b0;
    nxt_waddr = free_slot;
    nxt_wdata = head_r;
    prv_we    = 1'b0;
    prv_waddr = free_slot;
    prv_wdata = bdll_pkg::NULL_LINK;
    raddr     = head_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_item.opcode;
          key_nxt = in_item.key_value;
          out_item_nxt.out_key     = '0;
          out_item_nxt.status      = bdll_pkg::ST_DONE;
          out_item_nxt.entry_count = count_r;
          out_item_nxt.last_result = 1'b1;
          case (in_item.opcode)
            bdll_pkg::OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_item_nxt.status = bdll_pkg::ST_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                // new slot: key, next = old head, prev = null
                key_we = 1'b1;
                nxt_we = 1'b1;
                prv_we = 1'b1;
                free_map_nxt[free_slot] = 1'b0;
                head_nxt  = LW'(free_slot);
                count_nxt = count_r + CW'(1);
                if (head_ok) begin
                  cur_nxt   = head_r[AW-1:0];
                  slot_nxt  = free_slot;
                  state_nxt = S_INS;
                end else begin
                  tail_nxt                 = LW'(free_slot);
                  out_item_nxt.entry_count = count_r + CW'(1);
                  out_valid_nxt            = 1'b1;
                end
              end
            end
            bdll_pkg::OP_DEL_KEY, bdll_pkg::OP_DEL_FIRST,
            bdll_pkg::OP_DEL_LAST, bdll_pkg::OP_DUMP: begin
              if (!head_ok) begin
                out_item_nxt.status = bdll_pkg::ST_EMPTY;
                out_valid_nxt       = 1'b1;
              end else begin
                raddr = (in_item.opcode == bdll_pkg::OP_DEL_LAST) ?
                        tail_r[AW-1:0] : head_r[AW-1:0];
                cur_nxt   = raddr;
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // back link of the old head
        prv_we    = 1'b1;
        prv_waddr = cur_r;
        prv_wdata = LW'(slot_r);
        out_item_nxt.out_key     = '0;
        out_item_nxt.status      = bdll_pkg::ST_DONE;
        out_item_nxt.entry_count = count_r;
        out_item_nxt.last_result = 1'b1;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end

      S_WALK: begin
        // RAM outputs hold the entry at cur_r
        out_item_nxt.out_key     = '0;
        out_item_nxt.status      = bdll_pkg::ST_DONE;
        out_item_nxt.entry_count = count_r;
        out_item_nxt.last_result = 1'b1;
        raddr                    = nxt_rd[AW-1:0];
        case (op_r)
          bdll_pkg::OP_DUMP: begin
            out_item_nxt.out_key     = key_rd;
            out_item_nxt.last_result = !nxt_ok;
            out_valid_nxt            = 1'b1;
            if (nxt_ok) begin
              cur_nxt = nxt_rd[AW-1:0];
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            hit = (op_r != bdll_pkg::OP_DEL_KEY) || (key_rd == key_r);
            if (hit) begin
              if (prv_ok) begin
                nxt_we    = 1'b1;
                nxt_waddr = prv_rd[AW-1:0];
                nxt_wdata = nxt_rd;
              end else begin
                h = nxt_ok ? nxt_rd : bdll_pkg::NULL_LINK;
              end
              if (nxt_ok) begin
                prv_we    = 1'b1;
                prv_waddr = nxt_rd[AW-1:0];
                prv_wdata = prv_rd;
              end else begin
                t = prv_ok ? prv_rd : bdll_pkg::NULL_LINK;
              end
              if (!(h < LW'(CAPACITY))) begin
                t = bdll_pkg::NULL_LINK;
              end
              if (!(t < LW'(CAPACITY))) begin
                h = bdll_pkg::NULL_LINK;
              end
              head_nxt             = h;
              tail_nxt             = t;
              free_map_nxt[cur_r]  = 1'b1;
              count_nxt            = (count_r != '0) ? count_r - CW'(1) : count_r;
              out_item_nxt.entry_count = count_nxt;
              out_valid_nxt        = 1'b1;
              state_nxt            = S_IDLE;
            end else if (nxt_ok) begin
              cur_nxt = nxt_rd[AW-1:0];
            end else begin
              out_item_nxt.status = bdll_pkg::ST_NOT_FOUND;
              out_valid_nxt       = 1'b1;
              state_nxt           = S_IDLE;
            end
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= bdll_pkg::NULL_LINK;
      tail_r      <= bdll_pkg::NULL_LINK;
      count_r     <= '0;
      free_map_r  <= '1;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      free_map_r  <= free_map_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    slot_r <= slot_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sv/bdll_chk.sv
// Port-level checker for the bounded doubly linked list, bound to the top level.
`include "assert_macros.svh"

module bdll_chk #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bdll_pkg::out_item_t out_item
);

  localparam int CW = bdll_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic empty_res;
  logic key_res;

  assign empty_res = out_valid && (out_item.status == bdll_pkg::ST_EMPTY);
  assign key_res   = out_valid && (out_item.out_key != '0);

  `CHK_NXT(a_accept_acts, start && !busy, busy || out_valid, "transfer left no trace")
  `CHK_IMP(a_count_cap, out_valid, out_item.entry_count <= CAP_CNT, "count over capacity")
  `CHK_IMP(a_more_busy, out_valid && !out_item.last_result, busy, "idle with results pending")
  `CHK_IMP(a_empty_zero, empty_res, out_item.entry_count == '0, "empty status with entries")
  `CHK_IMP(a_key_done, key_res, out_item.status == bdll_pkg::ST_DONE, "key on a status result")

endmodule

bind bounded_doubly_linked_list bdll_chk #(.CAPACITY(CAPACITY)) u_bdll_chk (.*);
